>>> rtl/core/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg: shared types and constants of the four-step phase decoder
// angle constants in q60 radians, cordic word layout, angle kinds
// ----------------------------------------------------------------------------
package fsd_pkg;

  // pi/4 in q60 radians and its multiples
  localparam logic [63:0] QUARTER_PI = 64'h0C90FDAA22168C23;
  localparam logic [63:0] HALF_PI    = 64'h1921FB54442D1846;
  localparam logic [63:0] PI         = 64'h3243F6A8885A308C;
  localparam logic [63:0] TWO_PI     = 64'h6487ED5110B46118;

  localparam int unsigned CORDIC_STEPS = 58;
  localparam int unsigned VEC_SHIFT    = 52;
  localparam int unsigned ANGLE_BITS_DEFAULT = 16;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned PIXEL_W  = 19;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd16;
  localparam logic [PIXEL_W:0]    HALF_PIXEL_Q8 = 20'd128;

  // how the first-quadrant angle is found
  typedef enum logic [1:0] {
    KIND_CORDIC = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_RIGHT  = 2'd2,
    KIND_DIAG   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  c_neg;
    logic  s_neg;
  } side_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    side_t       side;
  } cordic_t;

  // atan(2^-i) in q60 radians from the truncated series, elaboration only
  function automatic logic [63:0] atan_pow2(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned k;
    sum = '0;
    if (i == 0) begin
      return QUARTER_PI;
    end
    for (k = 0; k < 31; k++) begin
      if (i * (2 * k + 1) <= 60) begin
        term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

endpackage

>>> rtl/core/fsd_front.sv
// ----------------------------------------------------------------------------
// fsd_front: sample differences and first-quadrant vector
// forms s and c, their magnitudes, quadrant signs and the angle kind
// ----------------------------------------------------------------------------
module fsd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic [fsd_pkg::SAMPLE_W-1:0]  sample_zero,
  input  logic [fsd_pkg::SAMPLE_W-1:0]  sample_quarter,
  input  logic [fsd_pkg::SAMPLE_W-1:0]  sample_half,
  input  logic [fsd_pkg::SAMPLE_W-1:0]  sample_three_quarter,
  output logic                          valid_out,
  output fsd_pkg::cordic_t              word_out
);

  logic signed [8:0] s_diff;
  logic signed [8:0] c_diff;
  logic [8:0] s_mag;
  logic [8:0] c_mag;
  logic [7:0] ax;
  logic [7:0] ay;
  fsd_pkg::cordic_t word_next;

  always_comb begin
    s_diff = $signed({1'b0, sample_zero}) - $signed({1'b0, sample_half});
    c_diff = $signed({1'b0, sample_quarter}) - $signed({1'b0, sample_three_quarter});
    s_mag  = s_diff[8] ? 9'(-s_diff) : 9'(s_diff);
    c_mag  = c_diff[8] ? 9'(-c_diff) : 9'(c_diff);
    ay     = s_mag[7:0];
    ax     = c_mag[7:0];

    word_next.x = 64'(ax) << fsd_pkg::VEC_SHIFT;
    word_next.y = 64'(ay) << fsd_pkg::VEC_SHIFT;
    word_next.z = '0;
    word_next.side.c_neg = c_diff[8];
    word_next.side.s_neg = s_diff[8];
    if (ay == 8'd0) begin
      word_next.side.kind = fsd_pkg::KIND_ZERO;
    end else if (ax == 8'd0) begin
      word_next.side.kind = fsd_pkg::KIND_RIGHT;
    end else if (ax == ay) begin
      word_next.side.kind = fsd_pkg::KIND_DIAG;
    end else begin
      word_next.side.kind = fsd_pkg::KIND_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_out <= word_next;
    end
  end

endmodule

>>> rtl/core/fsd_cordic_step.sv
// ----------------------------------------------------------------------------
// fsd_cordic_step: one vectoring micro-rotation of the cordic pipeline
// drives y towards zero and accumulates the angle in q60 radians
// ----------------------------------------------------------------------------
module fsd_cordic_step #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  fsd_pkg::cordic_t word_in,
  output logic             valid_out,
  output fsd_pkg::cordic_t word_out
);

  localparam logic [63:0] ANGLE = fsd_pkg::atan_pow2(STEP);

  logic [63:0] dx;
  logic [63:0] dy;
  logic        turn_down;
  fsd_pkg::cordic_t word_next;

  always_comb begin
    dx = 64'($signed(word_in.y) >>> STEP);
    dy = word_in.x >> STEP;
    turn_down = !word_in.y[63] && (word_in.y != 64'd0);
    word_next.side = word_in.side;
    if (turn_down) begin
      word_next.x = word_in.x + dx;
      word_next.y = word_in.y - dy;
      word_next.z = word_in.z + ANGLE;
    end else begin
      word_next.x = word_in.x - dx;
      word_next.y = word_in.y + dy;
      word_next.z = word_in.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_out <= word_next;
    end
  end

endmodule

>>> rtl/core/fsd_fold.sv
// ----------------------------------------------------------------------------
// fsd_fold: quadrant fold
// picks the first-quadrant angle and maps it onto [0, 2pi)
// ----------------------------------------------------------------------------
module fsd_fold (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  fsd_pkg::cordic_t word_in,
  output logic             valid_out,
  output logic [63:0]      angle_out
);

  logic [63:0] first_angle;
  logic [63:0] full_angle;
  logic [63:0] angle_next;

  always_comb begin
    case (word_in.side.kind)
      fsd_pkg::KIND_CORDIC: first_angle = word_in.z;
      fsd_pkg::KIND_ZERO:   first_angle = '0;
      fsd_pkg::KIND_RIGHT:  first_angle = fsd_pkg::HALF_PI;
      fsd_pkg::KIND_DIAG:   first_angle = fsd_pkg::QUARTER_PI;
      default:              first_angle = '0;
    endcase

    if (!word_in.side.c_neg && !word_in.side.s_neg) begin
      full_angle = first_angle;
    end else if (word_in.side.c_neg && !word_in.side.s_neg) begin
      full_angle = fsd_pkg::PI - first_angle;
    end else if (word_in.side.c_neg) begin
      full_angle = fsd_pkg::PI + first_angle;
    end else begin
      full_angle = fsd_pkg::TWO_PI - first_angle;
    end

    // a full turn wraps to zero
    angle_next = (full_angle >= fsd_pkg::TWO_PI) ? 64'd0 : full_angle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_out <= angle_next;
    end
  end

endmodule

>>> rtl/core/fsd_div_step.sv
// ----------------------------------------------------------------------------
// fsd_div_step: one restoring division step by 2pi
// doubles the remainder and yields one quotient bit of the turn fraction
// ----------------------------------------------------------------------------
module fsd_div_step #(
  parameter int unsigned QW = fsd_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [63:0]   rem_in,
  input  logic [QW-1:0] quo_in,
  output logic          valid_out,
  output logic [63:0]   rem_out,
  output logic [QW-1:0] quo_out
);

  logic [63:0] doubled;
  logic        take;

  always_comb begin
    doubled = {rem_in[62:0], 1'b0};
    take    = doubled >= fsd_pkg::TWO_PI;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? doubled - fsd_pkg::TWO_PI : doubled;
      quo_out <= {quo_in[QW-2:0], take};
    end
  end

endmodule

>>> rtl/core/fsd_scale.sv
// ----------------------------------------------------------------------------
// fsd_scale: period scaling and output buffer
// multiplies phase by the period, adds half a pixel, wraps, and holds
// finished words in an output register with one skid entry
// ----------------------------------------------------------------------------
module fsd_scale #(
  parameter int unsigned ANGLE_BITS = fsd_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic [ANGLE_BITS-1:0]         phase_in,
  input  logic [fsd_pkg::PERIOD_W-1:0]  fringe_period,
  output logic                          advance,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fsd_pkg::PHASE_W-1:0]   wrapped_phase,
  output logic [fsd_pkg::PIXEL_W-1:0]   pixel_offset
);

  localparam int unsigned PROD_W = ANGLE_BITS + fsd_pkg::PERIOD_W;
  localparam int unsigned WIDE_W =
    (ANGLE_BITS > fsd_pkg::PHASE_W) ? ANGLE_BITS : fsd_pkg::PHASE_W;
  localparam int unsigned WORD_W = fsd_pkg::PHASE_W + fsd_pkg::PIXEL_W;

  logic                  prod_valid;
  logic [PROD_W-1:0]     prod;
  logic [ANGLE_BITS-1:0] phase;

  logic [fsd_pkg::PIXEL_W-1:0] scaled;
  logic [fsd_pkg::PIXEL_W:0]   pix;
  logic [fsd_pkg::PIXEL_W:0]   lim;
  logic [fsd_pkg::PIXEL_W:0]   pix_wrapped;
  logic [WIDE_W-1:0]           phase_wide;
  logic [WORD_W-1:0]           word_new;

  logic              skid_valid;
  logic [WORD_W-1:0] out_word;
  logic [WORD_W-1:0] skid_word;
  logic              push;
  logic              pop;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= PROD_W'(phase_in) * PROD_W'(fringe_period);
      phase <= phase_in;
    end
  end

  // offset and wrap
  always_comb begin
    scaled      = prod[PROD_W-1:ANGLE_BITS-8];
    pix         = {1'b0, scaled} + fsd_pkg::HALF_PIXEL_Q8;
    lim         = {1'b0, fringe_period, 8'd0};
    pix_wrapped = (pix > lim) ? pix - lim : pix;
    phase_wide  = WIDE_W'(phase);
    word_new    = {pix_wrapped[fsd_pkg::PIXEL_W-1:0], phase_wide[fsd_pkg::PHASE_W-1:0]};
  end

  assign push    = en && prod_valid;
  assign pop     = out_valid && out_ready;
  assign advance = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_word <= skid_word;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_word <= word_new;
      end else begin
        skid_word <= word_new;
      end
    end
  end

  assign wrapped_phase = out_word[fsd_pkg::PHASE_W-1:0];
  assign pixel_offset  = out_word[WORD_W-1:fsd_pkg::PHASE_W];

endmodule

>>> rtl/core/four_step_phase_decode.sv
// ----------------------------------------------------------------------------
// four_step_phase_decode: four-step phase-shift decoder, one pixel a word
// wrapped phase by a 58-step cordic and restoring division by 2pi,
// then scaling by the fringe period into a q8 pixel offset
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata / data                               handshake
//  s_axis    in         [7:0] zero [15:8] quarter [23:16] half     tvalid/tready
//                       [31:24] three_quarter
//  m_axis    out        [15:0] wrapped_phase [34:16] pixel_offset  tvalid/tready
//  cfg       in         [10:0] fringe_period                       valid/ready
//
//  one word enters per clock while the output buffer has room, through these stages:
//  one front stage, 58 cordic stages, one fold, one division stage per
//  angle bit, one multiply stage and the output register
//  rst is synchronous and clears every valid bit and sets the period to 16
//  the output has one register plus one skid entry; s_axis_tready falls only
//  once the skid entry is filled, and then the whole pipeline holds in place
//  cfg_ready is always high; the user must write the period only while idle, the block does not enforce it
//
module four_step_phase_decode #(
  parameter int unsigned ANGLE_BITS = fsd_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // zero, quarter, half, three_quarter samples from bit 0 up
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // wrapped_phase, pixel_offset from bit 0 up, zero padding above
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fringe_period
  input  logic [10:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  localparam int unsigned STEPS = fsd_pkg::CORDIC_STEPS;

  logic                         en;
  logic [fsd_pkg::PERIOD_W-1:0] fringe_period;

  // cordic pipeline, entry 0 is the front stage output
  logic             cor_valid [0:STEPS];
  fsd_pkg::cordic_t cor_word  [0:STEPS];

  // division pipeline, entry 0 is the fold stage output
  logic                  div_valid [0:ANGLE_BITS];
  logic [63:0]           div_rem   [0:ANGLE_BITS];
  logic [ANGLE_BITS-1:0] div_quo   [0:ANGLE_BITS];

  logic [fsd_pkg::PHASE_W-1:0] wrapped_phase;
  logic [fsd_pkg::PIXEL_W-1:0] pixel_offset;

  // period register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fringe_period <= fsd_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fringe_period <= cfg_data;
    end
  end

  // the pipeline moves as one whenever the output buffer has room
  assign s_axis_tready = en;

  fsd_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .en                   (en),
    .valid_in             (s_axis_tvalid),
    .sample_zero          (s_axis_tdata[7:0]),
    .sample_quarter       (s_axis_tdata[15:8]),
    .sample_half          (s_axis_tdata[23:16]),
    .sample_three_quarter (s_axis_tdata[31:24]),
    .valid_out            (cor_valid[0]),
    .word_out             (cor_word[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    fsd_cordic_step #(
      .STEP (i)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (cor_valid[i]),
      .word_in   (cor_word[i]),
      .valid_out (cor_valid[i+1]),
      .word_out  (cor_word[i+1])
    );
  end

  fsd_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (cor_valid[STEPS]),
    .word_in   (cor_word[STEPS]),
    .valid_out (div_valid[0]),
    .angle_out (div_rem[0])
  );

  assign div_quo[0] = '0;

  for (genvar j = 0; j < ANGLE_BITS; j++) begin : g_div
    fsd_div_step #(
      .QW (ANGLE_BITS)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (div_valid[j]),
      .rem_in    (div_rem[j]),
      .quo_in    (div_quo[j]),
      .valid_out (div_valid[j+1]),
      .rem_out   (div_rem[j+1]),
      .quo_out   (div_quo[j+1])
    );
  end

  fsd_scale #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_scale (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .valid_in      (div_valid[ANGLE_BITS]),
    .phase_in      (div_quo[ANGLE_BITS]),
    .fringe_period (fringe_period),
    .advance       (en),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .wrapped_phase (wrapped_phase),
    .pixel_offset  (pixel_offset)
  );

  assign m_axis_tdata = {5'd0, pixel_offset, wrapped_phase};

  // a stall only ever happens with a word waiting at the output
  assert property (@(posedge clk) disable iff (rst) !en |-> m_axis_tvalid)
    else $error("pipeline stalled with no output word pending");

  // the pipeline only starts to stall after the output word was refused
  assert property (@(posedge clk) disable iff (rst)
    $fell(en) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("stall began without a refused output word");

endmodule
